// ----- rtl/assert_macros.svh -----
// Assertion helpers; every user provides clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define CHECK_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant check failed");

// cons must hold in the cycle after ante
`define CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/rem_pkg.sv -----
`timescale 1ns / 1ps

package rem_pkg;

  // port widths
  localparam int FIELD_W    = 32;
  localparam int MIDI_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // used widths of position and time
  localparam int POS_W  = 32;
  localparam int TIME_W = 32;
  localparam int MAG_W  = POS_W + 1;

  // speed in Q16.16; beyond 2^SPEED_BITS the multiplier is saturated anyway
  localparam int SPEED_FRAC = 16;
  localparam int SPEED_BITS = 13;
  localparam int PRE_SHIFT  = SPEED_FRAC - SPEED_BITS;
  localparam int CMP_W = (MAG_W + PRE_SHIFT > TIME_W) ? MAG_W + PRE_SHIFT : TIME_W;
  localparam int DCNT_W = $clog2(SPEED_BITS + 1);

  // acceleration curve: inc = floor((speed - 655) * 25 / 144), max 1024
  localparam int SENS_W = 16;
  localparam int MULT_W = 11;
  localparam int X_W    = 18;
  localparam int Y_W    = X_W - 4;
  localparam int RECIP_SHIFT = 17;
  localparam int PROD_W = Y_W + 14;
  localparam logic [SPEED_BITS-1:0] SPEED_THRESH = SPEED_BITS'(655);
  localparam logic [SPEED_BITS-1:0] INC_SAT_THRESH = SPEED_BITS'(5899);
  localparam logic [X_W-1:0] ACCEL_NUM = X_W'(25);
  // ceil(2^17 / 9); exact for quotients of values below 2^15
  localparam logic [Y_W-1:0] ACCEL_RECIP = Y_W'(14564);
  localparam logic [MULT_W-1:0] MULT_ONE = MULT_W'(256);
  localparam logic [MULT_W-1:0] MULT_MAX = MULT_W'(1280);

  // scale multiply: gain = sensitivity * multiplier, result >> 16, clamp 63
  localparam int GAIN_W  = SENS_W + MULT_W;
  localparam int DELTA_W = 6;
  localparam int ACC_W   = 16 + DELTA_W;
  localparam int SUM_W   = GAIN_W + 1;
  localparam int MCNT_W  = $clog2(MAG_W + 1);
  localparam logic [SUM_W-1:0] ACC_LIMIT = SUM_W'(1) << ACC_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENCODING_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_ENABLE  = 2'd2;

  // encodings
  localparam logic [1:0] MODE_OFFSET  = 2'd0;
  localparam logic [1:0] MODE_SIGNBIT = 2'd1;
  localparam logic [1:0] MODE_SIGNED  = 2'd2;
  localparam logic [1:0] MODE_INC     = 2'd3;
  localparam logic [MIDI_W-1:0] NEUTRAL   = 7'h40;
  localparam logic [MIDI_W-1:0] INC_UP    = 7'h01;
  localparam logic [MIDI_W-1:0] INC_DOWN  = 7'h7F;
  localparam logic [SENS_W-1:0] SENS_RESET = 16'd256;

  typedef struct packed {
    logic                  done;
    logic                  big;
    logic [SPEED_BITS-1:0] speed;
  } div_res_t;

  typedef struct packed {
    logic               done;
    logic [DELTA_W-1:0] scaled;
  } mul_res_t;

endpackage

// ----- rtl/relative_encoder_midi_mapper_top.sv -----
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// in        in_valid / in_ready     position[31:0], time_ms[31:0]
// out       out_valid / out_ready   midi_value[6:0]
// cfg       cfg_valid / cfg_ready   cfg_index[1:0], cfg_data[15:0]
//
// One request at a time. Unchanged position: S_DIFF goes straight to S_OUT.
// Moved, no acceleration: S_GAIN, then the 33-step scale multiply.
// Moved, with acceleration: the 13-step speed divider runs before that.
// Synchronous reset clears state, out_valid, the configuration and the stored position and time.
// in_ready is high in idle, also while a result waits; cfg_ready is always high.
// A stalled output holds the block in its final state until taken.

`include "assert_macros.svh"

module relative_encoder_midi_mapper_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rem_pkg::FIELD_W-1:0]    position,
  input  logic [rem_pkg::FIELD_W-1:0]    time_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rem_pkg::MIDI_W-1:0]     midi_value,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rem_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rem_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIFF   = 4'd1;
  localparam logic [3:0] S_DSTART = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_INC1   = 4'd4;
  localparam logic [3:0] S_INC2   = 4'd5;
  localparam logic [3:0] S_GAIN   = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state;

  // configuration
  logic [SENS_W-1:0] sensitivity;
  logic [1:0]        encoding_mode;
  logic              accel_enable;

  // history
  logic [POS_W-1:0]  last_position;
  logic [TIME_W-1:0] last_time;

  // per-request working registers
  logic [POS_W-1:0]      pos_q;
  logic [TIME_W-1:0]     time_q;
  logic [MAG_W-1:0]      mag_q;
  logic                  neg_q;
  logic [TIME_W-1:0]     dt_q;
  logic [SPEED_BITS-1:0] s_q;
  logic [Y_W-1:0]        y_q;
  logic [MULT_W-1:0]     mult_q;
  logic [DELTA_W-1:0]    scaled_q;

  div_res_t div_res;
  mul_res_t mul_res;

  logic [MAG_W-1:0]      cur_ext;
  logic [MAG_W-1:0]      prev_ext;
  logic [MAG_W-1:0]      diff_fwd;
  logic [MAG_W-1:0]      diff_rev;
  logic [TIME_W-1:0]     dt_w;
  logic                  use_accel;
  logic [SPEED_BITS-1:0] s_w;
  logic [X_W-1:0]        x_prod;
  logic [PROD_W-1:0]     inc_prod;
  logic [GAIN_W-1:0]     gain_w;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Exact difference of sign-extended positions; both orders, pick by sign.
  always_comb begin
    cur_ext   = {pos_q[POS_W-1], pos_q};
    prev_ext  = {last_position[POS_W-1], last_position};
    diff_fwd  = cur_ext - prev_ext;
    diff_rev  = prev_ext - cur_ext;
    dt_w      = time_q - last_time;
    // acceleration needs a prior time and a nonzero interval
    use_accel = accel_enable && (last_time != '0) && (dt_w != '0);
    s_w       = div_res.speed - SPEED_THRESH;
    x_prod    = X_W'(s_q) * ACCEL_NUM;
    inc_prod  = PROD_W'(y_q) * PROD_W'(ACCEL_RECIP);
    gain_w    = GAIN_W'(sensitivity) * GAIN_W'(mult_q);
  end

  rem_speed_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DSTART),
    .mag   (mag_q),
    .dt    (dt_q),
    .res   (div_res)
  );

  rem_scale_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_GAIN),
    .mag   (mag_q),
    .gain  (gain_w),
    .res   (mul_res)
  );

  function automatic logic [MIDI_W-1:0] encode(input logic [1:0] mode, input logic neg,
                                               input logic [DELTA_W-1:0] m);
    logic [MIDI_W-1:0] r;
    unique case (mode)
      MODE_OFFSET: begin
        r = neg ? (NEUTRAL - MIDI_W'(m)) : (NEUTRAL + MIDI_W'(m));
      end
      MODE_SIGNBIT, MODE_SIGNED: begin
        r = (m == '0) ? '0 : {neg, m};
      end
      MODE_INC: begin
        r = (m == '0) ? '0 : (neg ? INC_DOWN : INC_UP);
      end
    endcase
    return r;
  endfunction

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity   <= SENS_RESET;
      encoding_mode <= MODE_OFFSET;
      accel_enable  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SENSITIVITY:   sensitivity   <= cfg_data[SENS_W-1:0];
        REG_ENCODING_MODE: encoding_mode <= cfg_data[1:0];
        REG_ACCEL_ENABLE:  accel_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      last_position <= '0;
      last_time     <= '0;
    end else begin
      // a result taken while the next one is loaded is handled in S_OUT
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          if (pos_q == last_position) begin
            // no movement: neutral byte, history kept
            state <= S_OUT;
          end else begin
            last_position <= pos_q;
            last_time     <= time_q;
            state         <= use_accel ? S_DSTART : S_GAIN;
          end
        end
        S_DSTART: state <= S_DIV;
        S_DIV: begin
          if (div_res.done) begin
            if (div_res.big || (div_res.speed >= SPEED_THRESH &&
                                s_w < INC_SAT_THRESH)) begin
              state <= div_res.big ? S_GAIN : S_INC1;
            end else begin
              state <= S_GAIN;
            end
          end
        end
        S_INC1: state <= S_INC2;
        S_INC2: state <= S_GAIN;
        S_GAIN: state <= S_MUL;
        S_MUL: begin
          if (mul_res.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      pos_q  <= position[POS_W-1:0];
      time_q <= time_ms[TIME_W-1:0];
    end
    if (state == S_DIFF) begin
      neg_q    <= diff_fwd[MAG_W-1];
      mag_q    <= diff_fwd[MAG_W-1] ? diff_rev : diff_fwd;
      dt_q     <= dt_w;
      mult_q   <= MULT_ONE;
      scaled_q <= '0;
    end
    if (state == S_DIV && div_res.done) begin
      s_q <= s_w;
      // slow turns keep 1.0, fast ones clamp at 5.0
      if (div_res.big) begin
        mult_q <= MULT_MAX;
      end else if (div_res.speed < SPEED_THRESH) begin
        mult_q <= MULT_ONE;
      end else if (s_w >= INC_SAT_THRESH) begin
        mult_q <= MULT_MAX;
      end
    end
    if (state == S_INC1) begin
      // x / 144 as (x >> 4) / 9
      y_q <= x_prod[X_W-1:4];
    end
    if (state == S_INC2) begin
      mult_q <= MULT_ONE + inc_prod[RECIP_SHIFT +: MULT_W];
    end
    if (state == S_MUL && mul_res.done) begin
      scaled_q <= mul_res.scaled;
    end
    if (state == S_OUT && (!out_valid || out_ready)) begin
      midi_value <= encode(encoding_mode, neg_q, scaled_q);
    end
  end

  `CHECK_ALWAYS(a_div_done_in_div, !div_res.done || state == S_DIV)
  `CHECK_ALWAYS(a_mul_done_in_mul, !mul_res.done || state == S_MUL)
  `CHECK_ALWAYS(a_mult_range, state != S_GAIN || (mult_q >= MULT_ONE && mult_q <= MULT_MAX))
  `CHECK_NEXT(a_still_keeps_history, state == S_DIFF && pos_q == last_position, $stable(last_position) && $stable(last_time))

endmodule

// ----- rtl/rem_speed_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle: speed = |delta| * 2^16 / dt.
module rem_speed_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [rem_pkg::MAG_W-1:0]  mag,
  input  logic [rem_pkg::TIME_W-1:0] dt,
  output rem_pkg::div_res_t      res
);
  import rem_pkg::*;

  logic                  busy;
  logic                  done;
  logic                  big;
  logic [DCNT_W-1:0]     count;
  logic [TIME_W-1:0]     rem;
  logic [SPEED_BITS-1:0] quot;

  logic [CMP_W-1:0]  mag_sh;
  logic              over;
  logic [TIME_W:0]   rem2;
  logic              fits;

  always_comb begin
    mag_sh = CMP_W'(mag) << PRE_SHIFT;
    over   = mag_sh >= CMP_W'(dt);
    rem2   = {rem, 1'b0};
    fits   = rem2 >= {1'b0, dt};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      big   <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        big <= over;
        if (over) begin
          done <= 1'b1;
        end else begin
          busy  <= 1'b1;
          count <= DCNT_W'(SPEED_BITS);
        end
      end else if (busy) begin
        count <= count - DCNT_W'(1);
        if (count == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // partial remainder stays below dt
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= mag_sh[TIME_W-1:0];
    end else if (busy) begin
      rem  <= fits ? TIME_W'(rem2 - {1'b0, dt}) : rem2[TIME_W-1:0];
      quot <= {quot[SPEED_BITS-2:0], fits};
    end
  end

  assign res = '{done: done, big: big, speed: quot};

endmodule

// ----- rtl/rem_scale_mul.sv -----
`timescale 1ns / 1ps

// Shift-add multiply, magnitude MSB first, with sticky saturation at 64 << 16.
module rem_scale_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rem_pkg::MAG_W-1:0]  mag,
  input  logic [rem_pkg::GAIN_W-1:0] gain,
  output rem_pkg::mul_res_t          res
);
  import rem_pkg::*;

  logic              busy;
  logic              done;
  logic              sat;
  logic [MCNT_W-1:0] count;
  logic [MAG_W-1:0]  mag_sr;
  logic [GAIN_W-1:0] gain_q;
  logic [ACC_W-1:0]  acc;

  logic [SUM_W-1:0]  sum;
  logic              over;

  always_comb begin
    sum  = SUM_W'({acc, 1'b0}) + (mag_sr[MAG_W-1] ? SUM_W'(gain_q) : SUM_W'(0));
    over = sat || (sum >= ACC_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      sat   <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        sat   <= 1'b0;
        count <= MCNT_W'(MAG_W);
      end else if (busy) begin
        sat   <= over;
        count <= count - MCNT_W'(1);
        if (count == MCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_sr <= mag;
      gain_q <= gain;
      acc    <= '0;
    end else if (busy) begin
      mag_sr <= {mag_sr[MAG_W-2:0], 1'b0};
      if (!over) begin
        acc <= sum[ACC_W-1:0];
      end
    end
  end

  assign res = '{done: done,
                 scaled: sat ? {DELTA_W{1'b1}} : acc[ACC_W-1 -: DELTA_W]};

endmodule
